@@ rtl/bfm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Bloom filter membership block.
// No dependencies; imported by bloom_filter_membership_top and bfm_mix_unit.
package bfm_pkg;

    // Hash mix constants
    localparam logic [31:0] MIX_MUL  = 32'h5bd1_e995;
    localparam int          SHIFT_K  = 24;
    localparam int          SHIFT_H1 = 13;
    localparam int          SHIFT_H2 = 15;
    localparam logic [31:0] SEED_XOR = 32'd4;

    // Default sizing
    localparam int DEF_MAX_INDEX_BITS = 20;
    localparam int DEF_MAX_HASHES     = 64;

    // Configuration registers
    localparam int HASH_COUNT_W = 7;
    localparam int INDEX_BITS_W = 5;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 1'd1;

    localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 7'd1;
    localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RST = 5'd20;

    // Item modes
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

endpackage

@@ rtl/bloom_filter_membership_top.sv @@
`timescale 1ns / 1ps
// Bloom filter membership block: sequencer, seed table, bit store.
// Depends on bfm_pkg, bfm_ram and bfm_mix_unit.
//
// Input channel (i_valid / o_ready) takes one transaction per item: clear the
// bit store, load a seed, insert a key or query a key. Output channel
// (o_valid / i_ready) returns one transaction per item carrying o_present.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect in the next cycle.
//
// Steps per item, from the input transaction to o_valid:
//   load seed: write the seed table
//   insert / query: one probe for each of N seeds, N = hash_count saturated
//     to MAX_HASHES; a query stops early at the first clear bit
//   clear: write zero to every row of the bit store
// In each probe the single shared multiplier does the two seed-dependent
// multiplies (the two key multiplies run once per item), then the bit store
// word is read and, on an insert, written back with the bit set. One item is
// in work at a time; o_ready is high only when idle.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and only its completion waits for the register.
// After reset the bit store is cleared in a pass over all its rows (one row
// per cycle), during which o_ready stays low.
module bloom_filter_membership_top #(
    parameter int MAX_INDEX_BITS = bfm_pkg::DEF_MAX_INDEX_BITS,
    parameter int MAX_HASHES     = bfm_pkg::DEF_MAX_HASHES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_mode,
    input  logic [31:0]                    i_key,
    input  logic [5:0]                     i_seed_slot,
    input  logic [31:0]                    i_seed_word,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_present,
    input  logic                           i_cfg_we,
    input  logic [bfm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bfm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bfm_pkg::*;

    localparam int WORD_LG   = (MAX_INDEX_BITS > 6) ? 5 : MAX_INDEX_BITS - 2;
    localparam int WORD_W    = 1 << WORD_LG;
    localparam int ROW_AW    = MAX_INDEX_BITS - WORD_LG;
    localparam int ROWS      = 1 << ROW_AW;
    localparam int SEED_AW   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int CNT_W     = $clog2(MAX_HASHES + 1);
    localparam int HC_CMP_W  = (CNT_W > HASH_COUNT_W) ? CNT_W : HASH_COUNT_W;
    localparam int SLOT_W    = (CNT_W > 6) ? CNT_W : 6;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_K1, S_K2, S_KSAVE, S_H1, S_H2, S_H3, S_CHK, S_DONE
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_out_valid, n_out_valid;
    logic                      r_present, n_present;
    logic                      r_res, n_res;
    logic                      r_query, n_query;
    logic                      r_clr_resp, n_clr_resp;
    logic [ROW_AW-1:0]         r_clr, n_clr;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [CNT_W-1:0]          r_n, n_n;
    logic [31:0]               r_key, n_key;
    logic [31:0]               r_k, n_k;
    logic [ROW_AW-1:0]         r_row, n_row;
    logic [WORD_LG-1:0]        r_bitsel, n_bitsel;
    logic [HASH_COUNT_W-1:0]   r_hash_count;
    logic [INDEX_BITS_W-1:0]   r_index_bits;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic [31:0]               w_operand;
    logic [31:0]               w_prod;
    logic [31:0]               w_h2;
    logic [31:0]               w_h5;
    logic [INDEX_BITS_W-1:0]   w_ib_sat;
    logic [MAX_INDEX_BITS-1:0] w_mask;
    logic [MAX_INDEX_BITS-1:0] w_idx;
    logic [HC_CMP_W-1:0]       w_hc_ext;
    logic [HC_CMP_W-1:0]       w_hc_sat;
    logic [SLOT_W-1:0]         w_slot_ext;
    logic                      w_seed_we;
    logic [31:0]               w_seed_rdata;
    logic                      w_st_we;
    logic [ROW_AW-1:0]         w_st_waddr;
    logic [WORD_W-1:0]         w_st_wdata;
    logic [ROW_AW-1:0]         w_st_raddr;
    logic [WORD_W-1:0]         w_st_rdata;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_present = r_present;
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = r_out_valid && i_ready;

    // Active index mask and probe count, saturated to the built sizes
    assign w_ib_sat = (r_index_bits > INDEX_BITS_W'(MAX_INDEX_BITS))
                      ? INDEX_BITS_W'(MAX_INDEX_BITS) : r_index_bits;
    always_comb begin
        for (int j = 0; j < MAX_INDEX_BITS; j++) begin
            w_mask[j] = (INDEX_BITS_W'(j) < w_ib_sat);
        end
    end
    assign w_hc_ext = HC_CMP_W'(r_hash_count);
    assign w_hc_sat = (w_hc_ext > HC_CMP_W'(MAX_HASHES)) ? HC_CMP_W'(MAX_HASHES) : w_hc_ext;

    assign w_slot_ext = SLOT_W'(i_seed_slot);

    // Hash datapath around the shared multiplier
    assign w_h2  = w_prod ^ r_k;
    assign w_h5  = w_prod ^ (w_prod >> SHIFT_H2);
    assign w_idx = w_h5[MAX_INDEX_BITS-1:0] & w_mask;

    always_comb begin
        unique case (r_state)
            S_K1:    w_operand = r_key;
            S_K2:    w_operand = w_prod ^ (w_prod >> SHIFT_K);
            S_H1:    w_operand = w_seed_rdata ^ SEED_XOR;
            S_H2:    w_operand = w_h2 ^ (w_h2 >> SHIFT_H1);
            default: w_operand = r_key;
        endcase
    end

    bfm_mix_unit u_mix (
        .i_clk     (i_clk),
        .i_operand (w_operand),
        .o_product (w_prod)
    );

    assign w_seed_we = w_in_acc && (t_mode'(i_mode) == MODE_LOAD)
                       && (w_slot_ext < SLOT_W'(MAX_HASHES));

    bfm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_HASHES),
        .AW    (SEED_AW)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (w_seed_we),
        .i_waddr (w_slot_ext[SEED_AW-1:0]),
        .i_wdata (i_seed_word),
        .i_raddr (n_cnt[SEED_AW-1:0]),
        .o_rdata (w_seed_rdata)
    );

    assign w_st_raddr = w_idx[MAX_INDEX_BITS-1:WORD_LG];

    always_comb begin
        w_st_we    = 1'b0;
        w_st_waddr = r_row;
        w_st_wdata = w_st_rdata | (WORD_W'(1) << r_bitsel);
        if (r_state == S_CLEAR) begin
            w_st_we    = 1'b1;
            w_st_waddr = r_clr;
            w_st_wdata = '0;
        end else if (r_state == S_CHK && !r_query) begin
            w_st_we = 1'b1;
        end
    end

    bfm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !w_out_acc;
        n_present   = r_present;
        n_res       = r_res;
        n_query     = r_query;
        n_clr_resp  = r_clr_resp;
        n_clr       = r_clr;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_key       = r_key;
        n_k         = r_k;
        n_row       = r_row;
        n_bitsel    = r_bitsel;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + ROW_AW'(1);
                if (r_clr == {ROW_AW{1'b1}}) begin
                    n_res   = 1'b0;
                    n_state = r_clr_resp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_key   = i_key;
                    n_cnt   = '0;
                    n_n     = CNT_W'(w_hc_sat);
                    n_query = (t_mode'(i_mode) == MODE_QUERY);
                    n_res   = (t_mode'(i_mode) == MODE_QUERY);
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            n_clr      = '0;
                            n_clr_resp = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        MODE_LOAD: begin
                            n_res   = 1'b0;
                            n_state = S_DONE;
                        end
                        default: begin
                            // no seeds in use: nothing to probe
                            n_state = (w_hc_sat == '0) ? S_DONE : S_K1;
                        end
                    endcase
                end
            end
            S_K1:    n_state = S_K2;
            S_K2:    n_state = S_KSAVE;
            S_KSAVE: begin
                n_k     = w_prod;
                n_state = S_H1;
            end
            S_H1:    n_state = S_H2;
            S_H2:    n_state = S_H3;
            S_H3: begin
                n_row    = w_idx[MAX_INDEX_BITS-1:WORD_LG];
                n_bitsel = w_idx[WORD_LG-1:0];
                n_state  = S_CHK;
            end
            S_CHK: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_query && !w_st_rdata[r_bitsel]) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else if (n_cnt == r_n) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_H1;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_present   = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_out_valid  <= 1'b0;
            r_clr        <= '0;
            r_clr_resp   <= 1'b0;
            r_cnt        <= '0;
            r_hash_count <= HASH_COUNT_RST;
            r_index_bits <= INDEX_BITS_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr       <= n_clr;
            r_clr_resp  <= n_clr_resp;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HASH_COUNT: r_hash_count <= i_cfg_data[HASH_COUNT_W-1:0];
                    CFG_INDEX_BITS: r_index_bits <= i_cfg_data[INDEX_BITS_W-1:0];
                    default:        r_hash_count <= r_hash_count;
                endcase
            end
        end
        r_present <= n_present;
        r_res     <= n_res;
        r_query   <= n_query;
        r_n       <= n_n;
        r_key     <= n_key;
        r_k       <= n_k;
        r_row     <= n_row;
        r_bitsel  <= n_bitsel;
    end

endmodule

@@ rtl/bfm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bfm_mix_unit.sv @@
`timescale 1ns / 1ps
// Shared hash multiplier: registered 32-bit wrapping product by the mix constant.
// Depends on bfm_pkg.
module bfm_mix_unit (
    input  logic        i_clk,
    input  logic [31:0] i_operand,
    output logic [31:0] o_product
);
    import bfm_pkg::*;

    logic [31:0] r_product;

    always_ff @(posedge i_clk) begin
        r_product <= 32'(i_operand * MIX_MUL);
    end

    assign o_product = r_product;

endmodule

@@ dv/bloom_filter_membership_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bloom_filter_membership_top: drives clear, seed
// load, insert and query transactions and compares o_present with a predictor.
// Depends on bfm_pkg and the RTL of the block.
module bloom_filter_membership_top_tb;
    import bfm_pkg::*;

    localparam int MAX_INDEX_BITS = DEF_MAX_INDEX_BITS;
    localparam int MAX_HASHES     = DEF_MAX_HASHES;
    // A clear walks the whole store; the stall limit leaves room for a full clear.
    localparam int unsigned STALL_LIMIT = 100000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_mode      = MODE_CLEAR;
    logic [31:0]           i_key       = '0;
    logic [5:0]            i_seed_slot = '0;
    logic [31:0]           i_seed_word = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic                  o_present;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_HASH_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bloom_filter_membership_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_seed_slot (i_seed_slot),
        .i_seed_word (i_seed_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_present   (o_present),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Filter state as the block should hold it
    bit                      filter_bits [bit [31:0]];
    logic [31:0]             seed_words [MAX_HASHES];
    logic [HASH_COUNT_W-1:0] hash_count_cfg = HASH_COUNT_RST;
    logic [INDEX_BITS_W-1:0] index_bits_cfg = INDEX_BITS_RST;

    bit          pending_present [$];
    bit          no_idle = 1'b0;
    int unsigned failures = 0;
    int unsigned results_checked = 0;
    int unsigned present_hits = 0;
    int unsigned settings_used = 0;
    int unsigned clears_sent = 0;
    int unsigned loads_sent = 0;
    int unsigned inserts_sent = 0;
    int unsigned queries_sent = 0;

    initial begin : clock_gen
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [31:0] murmur_probe(logic [31:0] seed, logic [31:0] key,
                                                 logic [31:0] mask);
        logic [31:0] h;
        logic [31:0] k;
        h = seed ^ SEED_XOR;
        k = key * MIX_MUL;
        k = k ^ (k >> SHIFT_K);
        k = k * MIX_MUL;
        h = h * MIX_MUL;
        h = h ^ k;
        h = h ^ (h >> SHIFT_H1);
        h = h * MIX_MUL;
        h = h ^ (h >> SHIFT_H2);
        return h & mask;
    endfunction

    // Apply one transaction to the filter state and return the expected o_present.
    function automatic bit bloom_step(t_mode mode, logic [31:0] key, logic [5:0] slot,
                                      logic [31:0] word);
        int unsigned probes;
        int unsigned width;
        logic [31:0] mask;
        bit          hit;
        probes = (hash_count_cfg > MAX_HASHES) ? MAX_HASHES : hash_count_cfg;
        width  = (index_bits_cfg > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_bits_cfg;
        mask   = (32'd1 << width) - 32'd1;
        hit    = 1'b0;
        case (mode)
            MODE_CLEAR: filter_bits.delete();
            MODE_LOAD: begin
                if (slot < MAX_HASHES)
                    seed_words[slot] = word;
            end
            MODE_INSERT: begin
                for (int i = 0; i < probes; i++)
                    filter_bits[murmur_probe(seed_words[i], key, mask)] = 1'b1;
            end
            default: begin
                hit = 1'b1;
                for (int i = 0; i < probes; i++) begin
                    if (!filter_bits.exists(murmur_probe(seed_words[i], key, mask))) begin
                        hit = 1'b0;
                        break;
                    end
                end
            end
        endcase
        return hit;
    endfunction

    // Called in the time step of a rising edge; returns at the accepting edge.
    task automatic send_item(t_mode mode, logic [31:0] key, logic [5:0] slot,
                             logic [31:0] word);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_key       <= key;
        i_seed_slot <= slot;
        i_seed_word <= word;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_present.push_back(bloom_step(mode, key, slot, word));
        case (mode)
            MODE_CLEAR:  clears_sent++;
            MODE_LOAD:   loads_sent++;
            MODE_INSERT: inserts_sent++;
            default:     queries_sent++;
        endcase
    endtask

    task automatic send_key(t_mode mode, logic [31:0] key);
        send_item(mode, key, 6'($urandom_range(0, 63)), $urandom());
    endtask

    task automatic send_seed(logic [5:0] slot, logic [31:0] word);
        send_item(MODE_LOAD, $urandom(), slot, word);
    endtask

    // Hold off the sender until every result is back and the block is idle.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_present.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_filter(logic [HASH_COUNT_W-1:0] hashes,
                                  logic [INDEX_BITS_W-1:0] index_bits);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HASH_COUNT;
        i_cfg_data <= CFG_DATA_W'(hashes);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INDEX_BITS;
        i_cfg_data <= CFG_DATA_W'(index_bits);
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        hash_count_cfg  = hashes;
        index_bits_cfg  = index_bits;
        settings_used++;
    endtask

    task automatic test_directed_cases();
        send_seed(6'd0, 32'h0000_0000);
        send_seed(6'd1, 32'hffff_ffff);
        send_seed(6'd2, $urandom());
        send_seed(6'd3, $urandom());
        send_seed(6'd63, 32'hffff_ffff);
        // Reset settings: one hash over the full store
        send_key(MODE_INSERT, 32'h0000_0000);
        send_key(MODE_QUERY, 32'h0000_0000);
        send_key(MODE_QUERY, 32'hffff_ffff);
        wait_results_drained();
        program_filter(7'd4, 5'd20);
        send_key(MODE_INSERT, 32'hffff_ffff);
        send_key(MODE_QUERY, 32'hffff_ffff);
        send_key(MODE_QUERY, 32'h8000_0001);
        // No probes: insert is a no-op and every query hits
        wait_results_drained();
        program_filter(7'd0, 5'd20);
        send_key(MODE_INSERT, $urandom());
        send_key(MODE_QUERY, $urandom());
        // Zero-width index: everything lands on bit 0
        wait_results_drained();
        program_filter(7'd1, 5'd0);
        send_key(MODE_CLEAR, $urandom());
        send_key(MODE_QUERY, 32'h0000_0000);
        send_key(MODE_INSERT, $urandom());
        send_key(MODE_QUERY, $urandom());
        // Index width beyond the store saturates
        wait_results_drained();
        program_filter(7'd4, 5'd31);
        send_key(MODE_INSERT, 32'h0000_0000);
        send_key(MODE_QUERY, 32'h0000_0000);
        wait_results_drained();
    endtask

    task automatic test_seed_table_load();
        for (int s = 0; s < MAX_HASHES; s++)
            send_seed(6'(s), (s == 5) ? 32'h0 : $urandom());
        wait_results_drained();
    endtask

    // Mostly insert-then-query traffic with random keys, plus seed reloads and clears.
    task automatic run_traffic_phase(logic [HASH_COUNT_W-1:0] hashes,
                                     logic [INDEX_BITS_W-1:0] index_bits,
                                     int unsigned item_count);
        logic [31:0] inserted_keys [$];
        logic [31:0] key;
        int unsigned pick;
        wait_results_drained();
        program_filter(hashes, index_bits);
        send_key(MODE_CLEAR, $urandom());
        repeat (item_count) begin
            pick = $urandom_range(0, 999);
            key  = $urandom();
            if (pick < 3) begin
                send_key(MODE_CLEAR, key);
                inserted_keys.delete();
            end else if (pick < 23) begin
                send_seed(6'($urandom_range(0, 63)), key);
            end else if (pick < 430) begin
                send_key(MODE_INSERT, key);
                inserted_keys.push_back(key);
            end else if (pick < 850 && inserted_keys.size() != 0) begin
                send_key(MODE_QUERY,
                         inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
            end else begin
                send_key(MODE_QUERY, key);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [HASH_COUNT_W-1:0] phase_hashes [8] = '{7'd1, 7'd64, 7'd127, 7'd3,
                                                      7'd8, 7'd16, 7'd30, 7'd2};
        logic [INDEX_BITS_W-1:0] phase_bits [8]   = '{5'd20, 5'd20, 5'd31, 5'd4,
                                                      5'd10, 5'd1, 5'd20, 5'd12};
        for (int p = 0; p < 8; p++) begin
            if (p == 7)
                run_traffic_phase(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)), 205);
            else
                run_traffic_phase(phase_hashes[p], phase_bits[p], 205);
        end
    endtask

    initial begin : idle_pattern
        forever begin
            repeat ($urandom_range(40, 400)) @(posedge i_clk);
            no_idle <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : result_checker
        int unsigned stall;
        bit          want;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                if (pending_present.size() == 0) begin
                    $error("present: unexpected result transaction, actual %0b", o_present);
                    failures++;
                end else begin
                    want = pending_present.pop_front();
                    results_checked++;
                    if (want)
                        present_hits++;
                    if (o_present !== want) begin
                        $error("present mismatch: expected %0b, actual %0b", want, o_present);
                        failures++;
                    end
                end
                stall = draw_wait();
                if (stall != 0)
                    i_ready <= 1'b0;
            end else if (!i_ready) begin
                if (stall != 0)
                    stall--;
                if (stall == 0)
                    i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_seed_table_load();
        test_random_traffic();
        wait_results_drained();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d inserts, %0d queries, %0d seed loads, %0d clears over %0d settings.",
                 inserts_sent, queries_sent, loads_sent, clears_sent, settings_used);
        $display("Checked %0d results, %0d of them queries expected present.",
                 results_checked, present_hits);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ bloom_filter_membership_top.f @@
rtl/bfm_pkg.sv
rtl/bfm_ram.sv
rtl/bfm_mix_unit.sv
rtl/bloom_filter_membership_top.sv
dv/bloom_filter_membership_top_tb.sv
